### hdl/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared constants and codes for the positional PID controller unit.
// ----------------------------------------------------------------------------
package ppid_pkg;

    localparam int DATA_WIDTH_DEF     = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int GAIN_WIDTH         = 16;
    localparam int CFG_INDEX_WIDTH    = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GAIN_P   = 3'd0,
        CFG_GAIN_I   = 3'd1,
        CFG_GAIN_D   = 3'd2,
        CFG_SETPOINT = 3'd3,
        CFG_OUT_MAX  = 3'd4,
        CFG_OUT_MIN  = 3'd5
    } cfg_index_t;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

endpackage

### hdl/positional_pid_controller_unit.sv
// ----------------------------------------------------------------------------
// positional_pid_controller_unit
// Positional PID controller with integral anti-windup and output clamp.
//
//   channel   direction   handshake            payload
//   s_        in          s_tvalid/s_tready    tuser: op; tdata: measured
//   m_        out         m_tvalid/m_tready    tuser: limited; tdata: drive
//   cfg_      in          cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the result side does not stall; each item passes the
// input register, then the result register, with the whole PID step between.
// Integral and previous error update as an item moves into the result register.
// Synchronous active-low reset clears state; gains/setpoint 0, limits full range.
// A stalled result holds; the input register still takes an item behind it.
// ----------------------------------------------------------------------------
module positional_pid_controller_unit #(
    parameter int DATA_WIDTH     = ppid_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ppid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]           s_tdata,   // measured
    input  logic                                      s_tuser,   // op
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]           m_tdata,   // drive
    output logic                                      m_tuser,   // limited
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [ppid_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [(DATA_WIDTH > ppid_pkg::GAIN_WIDTH ?
                   DATA_WIDTH : ppid_pkg::GAIN_WIDTH)-1:0] cfg_data
);

    localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CFG_WIDTH   = DATA_WIDTH > ppid_pkg::GAIN_WIDTH ?
                                 DATA_WIDTH : ppid_pkg::GAIN_WIDTH;

    logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_p;
    logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_i;
    logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_d;
    logic signed [DATA_WIDTH-1:0]           setpoint;
    logic [DATA_WIDTH-2:0]                  out_max;
    logic signed [DATA_WIDTH-1:0]           out_min;

    logic                         in_valid_reg;
    logic                         op_reg;
    logic signed [DATA_WIDTH-1:0] measured_reg;
    logic                         out_valid_reg;
    logic [DATA_WIDTH-1:0]        drive_reg;
    logic                         limited_reg;

    logic                         advance;
    logic                         step_en;
    logic [DATA_WIDTH-1:0]        drive_next;
    logic                         limited_next;

    assign cfg_ready = 1'b1;

    ppid_cfg_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .CFG_WIDTH  (CFG_WIDTH)
    ) u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gain_p    (gain_p),
        .gain_i    (gain_i),
        .gain_d    (gain_d),
        .setpoint  (setpoint),
        .out_max   (out_max),
        .out_min   (out_min)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg       <= s_tuser;
            measured_reg <= s_tdata[DATA_WIDTH-1:0];
        end
    end

    ppid_core #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .op       (op_reg),
        .measured (measured_reg),
        .gain_p   (gain_p),
        .gain_i   (gain_i),
        .gain_d   (gain_d),
        .setpoint (setpoint),
        .out_max  (out_max),
        .out_min  (out_min),
        .drive    (drive_next),
        .limited  (limited_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            drive_reg   <= drive_next;
            limited_reg <= limited_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_WIDTH'(drive_reg);
    assign m_tuser  = limited_reg;

endmodule

### hdl/ppid_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppid_cfg_regs
// Configuration register file: gains, setpoint and output limits.
// ----------------------------------------------------------------------------
module ppid_cfg_regs #(
    parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF,
    parameter int CFG_WIDTH  = ppid_pkg::GAIN_WIDTH
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    input  logic [ppid_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_WIDTH-1:0]                     cfg_data,
    output logic signed [ppid_pkg::GAIN_WIDTH-1:0]   gain_p,
    output logic signed [ppid_pkg::GAIN_WIDTH-1:0]   gain_i,
    output logic signed [ppid_pkg::GAIN_WIDTH-1:0]   gain_d,
    output logic signed [DATA_WIDTH-1:0]             setpoint,
    output logic [DATA_WIDTH-2:0]                    out_max,
    output logic signed [DATA_WIDTH-1:0]             out_min
);

    logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_p_reg;
    logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_i_reg;
    logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_d_reg;
    logic signed [DATA_WIDTH-1:0]           setpoint_reg;
    logic [DATA_WIDTH-2:0]                  out_max_reg;
    logic signed [DATA_WIDTH-1:0]           out_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            setpoint_reg <= '0;
            out_max_reg  <= '1;
            out_min_reg  <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ppid_pkg::CFG_GAIN_P: begin
                    gain_p_reg <= cfg_data[ppid_pkg::GAIN_WIDTH-1:0];
                end
                ppid_pkg::CFG_GAIN_I: begin
                    gain_i_reg <= cfg_data[ppid_pkg::GAIN_WIDTH-1:0];
                end
                ppid_pkg::CFG_GAIN_D: begin
                    gain_d_reg <= cfg_data[ppid_pkg::GAIN_WIDTH-1:0];
                end
                ppid_pkg::CFG_SETPOINT: begin
                    setpoint_reg <= cfg_data[DATA_WIDTH-1:0];
                end
                ppid_pkg::CFG_OUT_MAX: begin
                    out_max_reg <= cfg_data[DATA_WIDTH-2:0];
                end
                ppid_pkg::CFG_OUT_MIN: begin
                    out_min_reg <= cfg_data[DATA_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign gain_p   = gain_p_reg;
    assign gain_i   = gain_i_reg;
    assign gain_d   = gain_d_reg;
    assign setpoint = setpoint_reg;
    assign out_max  = out_max_reg;
    assign out_min  = out_min_reg;

endmodule

### hdl/ppid_core.sv
// ----------------------------------------------------------------------------
// ppid_core
// Controller datapath: error, clamped integral, PID sum and output clamp.
// Holds the integral and previous error, updated when an item is taken.
// ----------------------------------------------------------------------------
module ppid_core #(
    parameter int DATA_WIDTH     = ppid_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = ppid_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   step_en,
    input  logic                                   op,
    input  logic signed [DATA_WIDTH-1:0]           measured,
    input  logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_p,
    input  logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_i,
    input  logic signed [ppid_pkg::GAIN_WIDTH-1:0] gain_d,
    input  logic signed [DATA_WIDTH-1:0]           setpoint,
    input  logic [DATA_WIDTH-2:0]                  out_max,
    input  logic signed [DATA_WIDTH-1:0]           out_min,
    output logic [DATA_WIDTH-1:0]                  drive,
    output logic                                   limited
);

    localparam int EW = DATA_WIDTH + 1;                // error
    localparam int SW = DATA_WIDTH + 2;                // raw sum / difference
    localparam int PW = ppid_pkg::GAIN_WIDTH + SW;     // product
    localparam int AW = PW + 2;                        // accumulator

    logic signed [DATA_WIDTH-1:0] error_sum_reg;
    logic signed [DATA_WIDTH-1:0] error_sum_next;
    logic signed [EW-1:0]         prior_error_reg;
    logic signed [EW-1:0]         prior_error_next;

    logic signed [EW-1:0] err;
    logic signed [SW-1:0] sum_raw;
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] lim_neg;
    logic signed [SW-1:0] sum_clamped;
    logic signed [SW-1:0] err_diff;
    logic signed [PW-1:0] prod_p;
    logic signed [PW-1:0] prod_i;
    logic signed [PW-1:0] prod_d;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] u_shift;
    logic signed [AW-1:0] max_ext;
    logic signed [AW-1:0] min_ext;
    logic signed [AW-1:0] u_clamped;
    logic                 u_limited;

    always_comb begin
        err = {setpoint[DATA_WIDTH-1], setpoint} - {measured[DATA_WIDTH-1], measured};

        sum_raw = {{2{error_sum_reg[DATA_WIDTH-1]}}, error_sum_reg}
                + {err[EW-1], err};
        lim     = {{(SW-DATA_WIDTH+2){1'b0}}, out_max[DATA_WIDTH-2:1]};
        lim_neg = -lim;
        if (sum_raw > lim) begin
            sum_clamped = lim;
        end else if (sum_raw < lim_neg) begin
            sum_clamped = lim_neg;
        end else begin
            sum_clamped = sum_raw;
        end

        err_diff = {err[EW-1], err} - {prior_error_reg[EW-1], prior_error_reg};

        prod_p = {{(PW-ppid_pkg::GAIN_WIDTH){gain_p[ppid_pkg::GAIN_WIDTH-1]}}, gain_p}
               * {{(PW-SW){err[EW-1]}}, err[EW-1], err};
        prod_i = {{(PW-ppid_pkg::GAIN_WIDTH){gain_i[ppid_pkg::GAIN_WIDTH-1]}}, gain_i}
               * {{(PW-SW){sum_clamped[SW-1]}}, sum_clamped};
        prod_d = {{(PW-ppid_pkg::GAIN_WIDTH){gain_d[ppid_pkg::GAIN_WIDTH-1]}}, gain_d}
               * {{(PW-SW){err_diff[SW-1]}}, err_diff};

        acc = {{2{prod_p[PW-1]}}, prod_p}
            + {{2{prod_i[PW-1]}}, prod_i}
            + {{2{prod_d[PW-1]}}, prod_d};
        u_shift = acc >>> GAIN_FRAC_BITS;

        max_ext = {{(AW-DATA_WIDTH+1){1'b0}}, out_max};
        min_ext = {{(AW-DATA_WIDTH){out_min[DATA_WIDTH-1]}}, out_min};
        if (u_shift > max_ext) begin
            u_clamped = max_ext;
            u_limited = 1'b1;
        end else if (u_shift < min_ext) begin
            u_clamped = min_ext;
            u_limited = 1'b1;
        end else begin
            u_clamped = u_shift;
            u_limited = 1'b0;
        end

        if (op == ppid_pkg::OP_CLEAR) begin
            error_sum_next   = '0;
            prior_error_next = '0;
            drive            = '0;
            limited          = 1'b0;
        end else begin
            error_sum_next   = sum_clamped[DATA_WIDTH-1:0];
            prior_error_next = err;
            drive            = u_clamped[DATA_WIDTH-1:0];
            limited          = u_limited;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg   <= '0;
            prior_error_reg <= '0;
        end else if (step_en) begin
            error_sum_reg   <= error_sum_next;
            prior_error_reg <= prior_error_next;
        end
    end

endmodule

### dv/positional_pid_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_pid_controller_unit_test
// Self-checking bench for the positional PID controller. A directed plan
// covers reset values, error extremes, clear, odd and zero output limits,
// inverted limits and an unused register index. Random phases follow, each
// with new gains, setpoint and limits. Samples go in as bursts with gaps while
// the result side stalls; results are checked against an in-bench PID model or a fixed value.
// ----------------------------------------------------------------------------
module positional_pid_controller_unit_test;

    localparam int  DW          = ppid_pkg::DATA_WIDTH_DEF;
    localparam int  FRAC        = ppid_pkg::GAIN_FRAC_BITS_DEF;
    localparam int  PHASES      = 12;
    localparam int  PHASE_ITEMS = 150;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam logic [ppid_pkg::CFG_INDEX_WIDTH-1:0] CFG_INDEX_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic                 limited;
    } pid_result_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t                            kind;
        logic                                 op;
        logic [ppid_pkg::CFG_INDEX_WIDTH-1:0] idx;
        logic [15:0]                          data;
        bit                                   typed;
        pid_result_t                          want;
    } plan_row_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [DW-1:0]                        s_tdata;   // measured
    logic                                 s_tuser;   // op
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [DW-1:0]                        m_tdata;   // drive
    logic                                 m_tuser;   // limited
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [ppid_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [15:0]                          cfg_data;

    // controller model: registers and state
    logic signed [15:0]   kp, ki, kd;
    logic signed [DW-1:0] target;
    logic [DW-2:0]        hi_lim;
    logic signed [DW-1:0] lo_lim;
    logic signed [DW-1:0] integ;
    logic signed [DW:0]   last_err;

    pid_result_t pending_drive_q[$];
    plan_row_t   plan[$];
    int          error_count = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    logic [7:0]  rx_pat = 8'hff;

    positional_pid_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic void set_register(logic [ppid_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                         logic [15:0] data);
        case (idx)
            ppid_pkg::CFG_GAIN_P:   kp = data;
            ppid_pkg::CFG_GAIN_I:   ki = data;
            ppid_pkg::CFG_GAIN_D:   kd = data;
            ppid_pkg::CFG_SETPOINT: target = data[DW-1:0];
            ppid_pkg::CFG_OUT_MAX:  hi_lim = data[DW-2:0];
            ppid_pkg::CFG_OUT_MIN:  lo_lim = data[DW-1:0];
            default: ;
        endcase
    endfunction

    function automatic pid_result_t pid_step(logic op, logic signed [DW-1:0] meas);
        pid_result_t r;
        longint e, lim, s, acc, u;
        r.drive   = '0;
        r.limited = 1'b0;
        if (op == ppid_pkg::OP_CLEAR) begin
            integ    = '0;
            last_err = '0;
            return r;
        end
        e   = longint'(target) - longint'(meas);
        lim = longint'(hi_lim) >>> 1;
        s   = longint'(integ) + e;
        if (s > lim)
            s = lim;
        else if (s < -lim)
            s = -lim;
        integ = s[DW-1:0];
        acc = longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - longint'(last_err));
        u = acc >>> FRAC;
        if (u > longint'(hi_lim)) begin
            u = longint'(hi_lim);
            r.limited = 1'b1;
        end else if (u < longint'(lo_lim)) begin
            u = longint'(lo_lim);
            r.limited = 1'b1;
        end
        last_err = e[DW:0];
        r.drive  = u[DW-1:0];
        return r;
    endfunction

    function automatic void row_item(logic op, logic [15:0] data, bit typed = 1'b0,
                                     logic [15:0] drive = '0, logic lim = 1'b0);
        plan.push_back('{ROW_ITEM, op, '0, data, typed, '{drive, lim}});
    endfunction

    function automatic void row_cfg(logic [ppid_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                    logic [15:0] data);
        plan.push_back('{ROW_CFG, ppid_pkg::OP_PROCESS, idx, data, 1'b0, '{16'h0000, 1'b0}});
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        int off;
        off = $urandom_range(0, 400);
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return 16'($urandom);
            default: return target + 16'(off - 200);
        endcase
    endfunction

    task automatic send_item(logic op, logic [15:0] data, bit typed, pid_result_t want);
        pid_result_t got;
        int gap;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        got = pid_step(op, data);
        pending_drive_q.push_back(typed ? want : got);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [ppid_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] data);
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_drive_q.size() != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        set_register(idx, data);
        @(negedge aclk);
    endtask

    // result side: the stall pattern is redrawn whenever its run counter expires
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
            rx_pat  = 8'($urandom);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= rx_pat[rx_left % 8];
            default: m_tready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge aclk) begin
        pid_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_drive_q.size() == 0) begin
                $error("unexpected result: drive %0d limited %0b", $signed(m_tdata), m_tuser);
                error_count++;
            end else begin
                want = pending_drive_q.pop_front();
                if (m_tdata !== want.drive) begin
                    $error("drive mismatch: expected %0d, got %0d",
                           want.drive, $signed(m_tdata));
                    error_count++;
                end
                if (m_tuser !== want.limited) begin
                    $error("limited mismatch: expected %0b, got %0b", want.limited, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] sample;
        logic        op;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ppid_pkg::OP_PROCESS;
        cfg_valid = 1'b0;
        cfg_index = ppid_pkg::CFG_GAIN_P;
        cfg_data  = '0;
        kp = '0; ki = '0; kd = '0; target = '0;
        hi_lim = 15'h7fff; lo_lim = 16'sh8000;
        integ = '0; last_err = '0;

        // zero gains after reset: output is always zero
        row_item(ppid_pkg::OP_PROCESS, 16'h0000, 1'b1, 16'h0000, 1'b0);
        row_item(ppid_pkg::OP_PROCESS, 16'h8000, 1'b1, 16'h0000, 1'b0);
        row_item(ppid_pkg::OP_PROCESS, 16'h7fff, 1'b1, 16'h0000, 1'b0);
        row_item(ppid_pkg::OP_CLEAR,   16'h5a5a, 1'b1, 16'h0000, 1'b0);
        // largest positive error, then none
        row_cfg(ppid_pkg::CFG_GAIN_P, 16'h0100);
        row_cfg(ppid_pkg::CFG_GAIN_I, 16'h0080);
        row_cfg(ppid_pkg::CFG_GAIN_D, 16'h8000);
        row_cfg(ppid_pkg::CFG_SETPOINT, 16'h7fff);
        row_item(ppid_pkg::OP_PROCESS, 16'h8000);
        row_item(ppid_pkg::OP_PROCESS, 16'h7fff);
        row_item(ppid_pkg::OP_PROCESS, 16'h0000);
        row_item(ppid_pkg::OP_CLEAR,   16'hffff, 1'b1, 16'h0000, 1'b0);
        // largest negative error, extreme gains
        row_cfg(ppid_pkg::CFG_GAIN_P, 16'h7fff);
        row_cfg(ppid_pkg::CFG_GAIN_I, 16'h8000);
        row_cfg(ppid_pkg::CFG_GAIN_D, 16'h7fff);
        row_cfg(ppid_pkg::CFG_SETPOINT, 16'h8000);
        row_item(ppid_pkg::OP_PROCESS, 16'h7fff);
        row_item(ppid_pkg::OP_PROCESS, 16'h8000);
        row_item(ppid_pkg::OP_PROCESS, 16'h8000);
        // odd upper limit: integral saturates at 50
        row_cfg(ppid_pkg::CFG_OUT_MAX, 16'h0065);
        row_cfg(ppid_pkg::CFG_OUT_MIN, 16'hff00);
        row_cfg(ppid_pkg::CFG_GAIN_P, 16'h0010);
        row_cfg(ppid_pkg::CFG_GAIN_I, 16'h0100);
        row_cfg(ppid_pkg::CFG_GAIN_D, 16'h0000);
        row_cfg(ppid_pkg::CFG_SETPOINT, 16'h0000);
        repeat (4) row_item(ppid_pkg::OP_PROCESS, 16'hfff6);
        // inverted limits, pure proportional
        row_cfg(ppid_pkg::CFG_OUT_MAX, 16'h0064);
        row_cfg(ppid_pkg::CFG_OUT_MIN, 16'h00c8);
        row_cfg(ppid_pkg::CFG_GAIN_P, 16'h0100);
        row_cfg(ppid_pkg::CFG_GAIN_I, 16'h0000);
        row_item(ppid_pkg::OP_PROCESS, 16'hff6a, 1'b1, 16'd100, 1'b1);
        row_item(ppid_pkg::OP_PROCESS, 16'hffce, 1'b1, 16'd200, 1'b1);
        row_cfg(CFG_INDEX_UNUSED, 16'hffff);
        row_item(ppid_pkg::OP_PROCESS, 16'hff6a, 1'b1, 16'd100, 1'b1);
        // zero upper limit
        row_cfg(ppid_pkg::CFG_OUT_MAX, 16'h0000);
        row_cfg(ppid_pkg::CFG_OUT_MIN, 16'h8000);
        row_item(ppid_pkg::OP_PROCESS, 16'h0005);
        row_item(ppid_pkg::OP_PROCESS, 16'hfffb, 1'b1, 16'h0000, 1'b1);
        // top bit of out_max is dropped
        row_cfg(ppid_pkg::CFG_OUT_MAX, 16'hffff);
        row_item(ppid_pkg::OP_PROCESS, 16'h8000, 1'b1, 16'h7fff, 1'b1);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_item(plan[i].op, plan[i].data, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(ppid_pkg::CFG_GAIN_P, pick_gain());
            write_reg(ppid_pkg::CFG_GAIN_I, pick_gain());
            write_reg(ppid_pkg::CFG_GAIN_D, pick_gain());
            case ($urandom_range(0, 5))
                0: write_reg(ppid_pkg::CFG_SETPOINT, 16'h8000);
                1: write_reg(ppid_pkg::CFG_SETPOINT, 16'h7fff);
                default: write_reg(ppid_pkg::CFG_SETPOINT, 16'($urandom));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(ppid_pkg::CFG_OUT_MAX, 16'h0000);
                1: write_reg(ppid_pkg::CFG_OUT_MAX, 16'hffff);
                2: write_reg(ppid_pkg::CFG_OUT_MAX, 16'h7ffe);
                default: write_reg(ppid_pkg::CFG_OUT_MAX, 16'($urandom));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(ppid_pkg::CFG_OUT_MIN, 16'h8000);
                1: write_reg(ppid_pkg::CFG_OUT_MIN, 16'h7fff);
                2: write_reg(ppid_pkg::CFG_OUT_MIN, 16'($urandom));
                default: write_reg(ppid_pkg::CFG_OUT_MIN,
                                   16'(-int'($urandom_range(0, 32768))));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(6, 7)), 16'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op     = ($urandom_range(0, 24) == 0) ? ppid_pkg::OP_CLEAR
                                                       : ppid_pkg::OP_PROCESS;
                sample = pick_sample();
                send_item(op, sample, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_drive_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### positional_pid_controller_unit.f
hdl/ppid_pkg.sv
hdl/ppid_cfg_regs.sv
hdl/ppid_core.sv
hdl/positional_pid_controller_unit.sv
dv/positional_pid_controller_unit_test.sv
